>>> rtl/core/pdma_pkg.sv
// package: shared constants, config struct and event codes for the presence detector
`timescale 1ns / 1ps
package pdma_pkg;

	// default parameter values
	localparam int DEF_WINDOW      = 10;
	localparam int DEF_SAMPLE_BITS = 12;

	// register widths and reset values
	localparam int DELTA_W    = 12;
	localparam int TIMEOUT_W  = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int QUIET_W    = 16;

	localparam logic [DELTA_W-1:0]   DELTA_RESET   = 12'd500;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELTA_THRESHOLD = 1'd0,
		CFG_TIMEOUT_SAMPLES = 1'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_OCCUPIED = 2'd1,
		EV_EMPTY    = 2'd2
	} event_t;

	typedef struct packed {
		logic [DELTA_W-1:0]   delta_threshold;
		logic [TIMEOUT_W-1:0] timeout_samples;
	} cfg_t;

endpackage

>>> rtl/core/pdma_sample_if.sv
// interface: sample channel, valid/ready plus one converter reading
`timescale 1ns / 1ps
interface pdma_sample_if #(
	parameter int SAMPLE_BITS = pdma_pkg::DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

>>> rtl/core/pdma_result_if.sv
// interface: result channel, valid/ready plus presence flag, event and mean
`timescale 1ns / 1ps
interface pdma_result_if #(
	parameter int SAMPLE_BITS = pdma_pkg::DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic                   occupied;
	logic [1:0]             event_code;
	logic [SAMPLE_BITS-1:0] mean_value;

	modport source (output valid, output occupied, output event_code, output mean_value,
		input ready);
	modport sink   (input valid, input occupied, input event_code, input mean_value,
		output ready);
endinterface

>>> rtl/core/pdma_cfg_regs.sv
// module: threshold and timeout registers behind the plain write port
`timescale 1ns / 1ps
module pdma_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pdma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdma_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pdma_pkg::cfg_t                     cfg
);
	pdma_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_threshold <= pdma_pkg::DELTA_RESET;
			cfg_q.timeout_samples <= pdma_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (pdma_pkg::cfg_idx_t'(cfg_index))
				pdma_pkg::CFG_DELTA_THRESHOLD: begin
					cfg_q.delta_threshold <= cfg_data[pdma_pkg::DELTA_W-1:0];
				end
				pdma_pkg::CFG_TIMEOUT_SAMPLES: begin
					cfg_q.timeout_samples <= cfg_data[pdma_pkg::TIMEOUT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> rtl/core/pdma_avg.sv
// module: sample window, running total and mean by reciprocal multiply
`timescale 1ns / 1ps
module pdma_avg #(
	parameter int WINDOW      = pdma_pkg::DEF_WINDOW,
	parameter int SAMPLE_BITS = pdma_pkg::DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pdma_sample_if.sink            samples,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] out_sample,
	output logic [SAMPLE_BITS-1:0] out_mean
);
	localparam int WIN_BITS = $clog2(WINDOW);
	localparam int TOTAL_W  = SAMPLE_BITS + WIN_BITS;
	localparam int SHIFT    = TOTAL_W + WIN_BITS;
	localparam int RECIP_W  = TOTAL_W + 1;
	localparam int PROD_W   = TOTAL_W + RECIP_W;
	// ceil(2^SHIFT / WINDOW): exact floor division for every total below 2^TOTAL_W
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic                   valid_s1, valid_s2, valid_s3;
	logic [SAMPLE_BITS-1:0] sample_s1, sample_s2, sample_s3;
	logic [SAMPLE_BITS-1:0] mean_s3;
	logic [TOTAL_W-1:0]     total_q;
	logic [SAMPLE_BITS-1:0] ring_q [WINDOW];

	logic               adv1, adv2, adv3;
	logic [TOTAL_W-1:0] total_next;
	logic [PROD_W-1:0]  prod;

	assign adv3 = !valid_s3 || out_ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign samples.ready = adv1;

	// oldest entry leaves the total as the new one enters
	assign total_next = total_q - TOTAL_W'(ring_q[WINDOW-1]) + TOTAL_W'(sample_s1);
	assign prod       = PROD_W'(total_q) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			total_q  <= '0;
			for (int k = 0; k < WINDOW; k++) begin
				ring_q[k] <= '0;
			end
		end else begin
			if (adv1) begin
				valid_s1 <= samples.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					total_q   <= total_next;
					ring_q[0] <= sample_s1;
					for (int k = 1; k < WINDOW; k++) begin
						ring_q[k] <= ring_q[k-1];
					end
				end
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && samples.valid) begin
			sample_s1 <= samples.sample_value;
		end
		if (adv2 && valid_s1) begin
			sample_s2 <= sample_s1;
		end
		if (adv3 && valid_s2) begin
			sample_s3 <= sample_s2;
			mean_s3   <= prod[SHIFT +: SAMPLE_BITS];
		end
	end

	assign out_valid  = valid_s3;
	assign out_sample = sample_s3;
	assign out_mean   = mean_s3;
endmodule

>>> rtl/core/pdma_detect.sv
// module: deviation test, presence state, quiet counter and result register
`timescale 1ns / 1ps
module pdma_detect #(
	parameter int SAMPLE_BITS = pdma_pkg::DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pdma_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic [SAMPLE_BITS-1:0] in_mean,
	pdma_result_if.source          results
);
	localparam int CMP_W = (SAMPLE_BITS > pdma_pkg::DELTA_W) ? SAMPLE_BITS : pdma_pkg::DELTA_W;

	logic                          valid_q;
	logic                          flag_q;
	logic [pdma_pkg::QUIET_W-1:0]  quiet_q;
	pdma_pkg::event_t              event_q;
	logic [SAMPLE_BITS-1:0]        mean_q;

	logic                          adv;
	logic [SAMPLE_BITS-1:0]        diff;
	logic                          deviates;
	logic [pdma_pkg::QUIET_W-1:0]  quiet_inc;
	logic                          timed_out;

	assign adv      = !valid_q || results.ready;
	assign in_ready = adv;

	assign diff      = (in_sample > in_mean) ? (in_sample - in_mean) : (in_mean - in_sample);
	assign deviates  = CMP_W'(diff) > CMP_W'(cfg.delta_threshold);
	// saturating count of quiet samples
	assign quiet_inc = (&quiet_q) ? quiet_q : quiet_q + 1'b1;
	assign timed_out = quiet_inc >= pdma_pkg::QUIET_W'(cfg.timeout_samples);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			flag_q  <= 1'b0;
			quiet_q <= '0;
			event_q <= pdma_pkg::EV_NONE;
		end else if (adv) begin
			valid_q <= in_valid;
			if (in_valid) begin
				event_q <= pdma_pkg::EV_NONE;
				if (deviates) begin
					quiet_q <= '0;
					if (!flag_q) begin
						flag_q  <= 1'b1;
						event_q <= pdma_pkg::EV_OCCUPIED;
					end
				end else begin
					quiet_q <= quiet_inc;
					if (flag_q && timed_out) begin
						flag_q  <= 1'b0;
						event_q <= pdma_pkg::EV_EMPTY;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			mean_q <= in_mean;
		end
	end

	assign results.valid      = valid_q;
	assign results.occupied   = flag_q;
	assign results.event_code = event_q;
	assign results.mean_value = mean_q;
endmodule

>>> rtl/core/presence_detect_moving_average.sv
// top level: moving-average presence detector with config registers
//
//   channel   dir  beat contents                            handshake
//   samples   in   sample_value                             valid/ready
//   results   out  occupied, event_code, mean_value         valid/ready
//   cfg       in   cfg_index, cfg_data                      cfg_we, no wait
//
// one sample per cycle sustained while results are taken; input, total, mean, result registers
// the running-total update (subtract oldest, add newest) is a registered loop; the
// reciprocal multiply for the mean has its own register stage
// reset clears the window to zero, the total, the presence flag and the quiet count,
// and loads threshold 500 and timeout 40; no clearing pass, ready right after reset
// a stalled result beat holds its register; earlier stages keep filling bubbles and
// sample ready drops only once every stage holds an item
`timescale 1ns / 1ps
module presence_detect_moving_average #(
	parameter int WINDOW      = pdma_pkg::DEF_WINDOW,
	parameter int SAMPLE_BITS = pdma_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [pdma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdma_pkg::CFG_DATA_W-1:0] cfg_data,
	// data channels
	pdma_sample_if.sink                     samples,
	pdma_result_if.source                   results
);
	// threshold and timeout; the user must write them only while idle, the block does not enforce it
	pdma_pkg::cfg_t cfg;

	// averaging stages to decision stage
	logic                   avg_valid;
	logic                   avg_ready;
	logic [SAMPLE_BITS-1:0] avg_sample;
	logic [SAMPLE_BITS-1:0] avg_mean;

	pdma_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register, window shift line with running total, mean multiply
	pdma_avg #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.out_valid  (avg_valid),
		.out_ready  (avg_ready),
		.out_sample (avg_sample),
		.out_mean   (avg_mean)
	);

	// deviation compare, presence state and result register
	pdma_detect #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_detect (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (avg_valid),
		.in_ready  (avg_ready),
		.in_sample (avg_sample),
		.in_mean   (avg_mean),
		.results   (results)
	);
endmodule

>>> verif/presence_detect_moving_average_tb.sv
// testbench: presence_detect_moving_average, directed table, long timeout run, random segments vs predictor
`timescale 1ns / 1ps
module presence_detect_moving_average_tb;

	localparam int WINDOW        = pdma_pkg::DEF_WINDOW;
	localparam int SAMPLE_BITS   = pdma_pkg::DEF_SAMPLE_BITS;
	localparam int DRAIN_CYCLES  = 8;       // settle wait after the last pending result beat has left
	localparam int LONG_HOLD     = 60;      // receiver hold-off, long enough to fill every stage
	localparam int PHASE_ITEMS   = 150;
	localparam int RANDOM_PHASES = 8;
	localparam int LONG_QUIET    = 120;     // quiet run that outlasts LONG_TIMEOUT
	localparam int LONG_TIMEOUT  = 100;
	localparam int CYCLE_LIMIT   = 150000;
	localparam int DIRECTED_N    = 22;

	// one result beat as the predictor sees it
	typedef struct packed {
		logic                   occupied;
		pdma_pkg::event_t       ev;
		logic [SAMPLE_BITS-1:0] mean;
	} detection_t;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	// directed row: a sample, or a pair of register values (delta data, timeout data)
	typedef struct packed {
		row_kind_t   kind;
		logic [15:0] a;
		logic [15:0] b;
		logic        pinned;
		detection_t  result;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pdma_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pdma_pkg::CFG_DATA_W-1:0] cfg_data;

	pdma_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples ();
	pdma_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) results ();

	presence_detect_moving_average #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples),
		.results   (results)
	);

	// predictor state: its own copy of the window, total, flag, quiet count and registers
	logic [SAMPLE_BITS-1:0]           win_q [WINDOW];
	int                               win_pos;
	int                               win_sum;
	logic                             occ_state;
	logic [pdma_pkg::QUIET_W-1:0]     quiet_run;
	logic [pdma_pkg::DELTA_W-1:0]     cfg_delta;
	logic [pdma_pkg::TIMEOUT_W-1:0]   cfg_timeout;

	detection_t pending_results [$];

	// typed-in expectation travelling with the beat, used instead of the prediction
	bit         pin_has;
	detection_t pin_result;

	bit idle_on;
	bit hold_request;
	int fail_count;
	int samples_sent;
	int cycle_count;
	int occ_events;
	int empty_events;
	int settings_used;

	// expected results are read off at a glance: first beat after reset is all zero,
	// a full-scale jump into a near-empty window flags presence with mean 4095/10
	stim_row_t directed_rows [DIRECTED_N] = '{
		'{ROW_SAMPLE, 16'd0,    16'd0, 1'b1, '{1'b0, pdma_pkg::EV_NONE,     12'd0}},
		'{ROW_SAMPLE, 16'd4095, 16'd0, 1'b1, '{1'b1, pdma_pkg::EV_OCCUPIED, 12'd409}},
		'{ROW_SAMPLE, 16'd4095, 16'd0, 1'b1, '{1'b1, pdma_pkg::EV_NONE,     12'd819}},
		'{ROW_SAMPLE, 16'd0,      16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd2048,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd2047,   16'd0,      1'b0, '0},
		// smallest threshold and shortest timeout
		'{ROW_CFG,    16'd0,      16'd1,      1'b0, '0},
		'{ROW_SAMPLE, 16'd1365,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd1365,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd2730,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd4095,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd0,      16'd0,      1'b0, '0},
		// largest threshold with junk in the upper data bits, zero timeout
		'{ROW_CFG,    16'hFFFF,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd100,    16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd3000,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd4095,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd0,      16'd0,      1'b0, '0},
		'{ROW_CFG,    16'd500,    16'd3,      1'b0, '0},
		'{ROW_SAMPLE, 16'd4095,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd0,      16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd4095,   16'd0,      1'b0, '0},
		'{ROW_SAMPLE, 16'd1,      16'd0,      1'b0, '0}
	};

	// advance the window, update the running total, compare the sample with the mean
	function automatic detection_t detector_step(input logic [SAMPLE_BITS-1:0] v);
		detection_t             r;
		logic [SAMPLE_BITS-1:0] avg;
		logic [SAMPLE_BITS-1:0] dev;
		win_pos = (win_pos == WINDOW - 1) ? 0 : win_pos + 1;
		win_sum = win_sum - int'(win_q[win_pos]) + int'(v);
		win_q[win_pos] = v;
		avg = SAMPLE_BITS'(win_sum / WINDOW);
		dev = (v > avg) ? v - avg : avg - v;
		r.ev = pdma_pkg::EV_NONE;
		if (dev > cfg_delta) begin
			// deviation: restart the quiet run, flag presence if empty
			quiet_run = '0;
			if (!occ_state) begin
				occ_state = 1'b1;
				r.ev = pdma_pkg::EV_OCCUPIED;
				occ_events++;
			end
		end else begin
			// quiet sample: count it, saturating, and time out an occupied block
			if (quiet_run != '1)
				quiet_run++;
			if (occ_state && quiet_run >= cfg_timeout) begin
				occ_state = 1'b0;
				r.ev = pdma_pkg::EV_EMPTY;
				empty_events++;
			end
		end
		r.occupied = occ_state;
		r.mean = avg;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hang guard, sized from the slowest legal run several times over
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** presence_detect_moving_average: FAILED **");
			$finish;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin : result_sink
		int n;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// hold off long enough that every stage fills and sample ready drops
				results.ready <= 1'b0;
				for (n = 0; n < LONG_HOLD; n++)
					@(posedge clk);
				hold_request = 1'b0;
				results.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				results.ready <= 1'b1;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on every sample beat, check every result beat against the oldest
	always @(posedge clk) begin : beat_monitor
		detection_t predicted;
		detection_t want;
		if (arst_n) begin
			if (samples.valid && samples.ready) begin
				predicted = detector_step(samples.sample_value);
				pending_results.push_back(pin_has ? pin_result : predicted);
			end
			if (results.valid && results.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with no sample pending");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (results.occupied !== want.occupied) begin
						$error("occupied: expected %0d, got %0d", want.occupied, results.occupied);
						fail_count++;
					end
					if (results.event_code !== want.ev) begin
						$error("event_code: expected %0d, got %0d", want.ev, results.event_code);
						fail_count++;
					end
					if (results.mean_value !== want.mean) begin
						$error("mean_value: expected %0d, got %0d", want.mean, results.mean_value);
						fail_count++;
					end
				end
			end
		end
	end

	// offer one sample beat, maybe after a gap, and wait for it to be taken
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] v, input bit pinned,
		input detection_t pinned_result);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample_value <= v;
		pin_has <= pinned;
		pin_result <= pinned_result;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// stop offering, let every pending result come out, then let the pipe settle
	task automatic drain_results();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers, back to back; only called with the block idle
	task automatic write_regs(input logic [15:0] delta_data, input logic [15:0] timeout_data);
		cfg_we <= 1'b1;
		cfg_index <= pdma_pkg::CFG_DELTA_THRESHOLD;
		cfg_data <= delta_data;
		@(posedge clk);
		cfg_index <= pdma_pkg::CFG_TIMEOUT_SAMPLES;
		cfg_data <= timeout_data;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_delta = delta_data[pdma_pkg::DELTA_W-1:0];
		cfg_timeout = timeout_data;
		settings_used++;
	endtask

	// threshold and timeout drawn with the extremes weighted in
	task automatic random_settings();
		logic [pdma_pkg::DELTA_W-1:0]   d;
		logic [pdma_pkg::TIMEOUT_W-1:0] t;
		case ($urandom_range(0, 3))
			0: d = '0;
			1: d = '1;
			2: d = pdma_pkg::DELTA_W'($urandom_range(1, 300));
			default: d = pdma_pkg::DELTA_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: t = 16'd1;
			1: t = 16'd0;
			2: t = 16'($urandom_range(2, 40));
			default: t = 16'($urandom_range(41, 65535));
		endcase
		write_regs({4'($urandom), d}, t);
	endtask

	// a steady level with small jitter, so the mean settles and steps stand out;
	// some samples and some whole segments are plain noise
	task automatic send_segment();
		int  level;
		int  spread;
		int  len;
		int  k;
		int  s;
		bit  noisy;
		level = $urandom_range(0, 4095);
		spread = $urandom_range(0, 80);
		len = $urandom_range(1, 40);
		noisy = ($urandom_range(0, 7) == 0);
		for (k = 0; k < len; k++) begin
			if (noisy || $urandom_range(0, 5) == 0) begin
				s = $urandom_range(0, 4095);
			end else begin
				s = level + int'($urandom_range(0, 2 * spread)) - spread;
				if (s < 0)
					s = 0;
				if (s > 4095)
					s = 4095;
			end
			send_sample(SAMPLE_BITS'(s), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int i;
		int k;
		int phase;
		int start;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pdma_pkg::CFG_DELTA_THRESHOLD;
		cfg_data = '0;
		samples.valid = 1'b0;
		samples.sample_value = '0;
		pin_has = 1'b0;
		pin_result = '0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		// predictor mirrors the reset state of the block
		for (i = 0; i < WINDOW; i++)
			win_q[i] = '0;
		win_pos = 0;
		win_sum = 0;
		occ_state = 1'b0;
		quiet_run = '0;
		cfg_delta = pdma_pkg::DELTA_RESET;
		cfg_timeout = pdma_pkg::TIMEOUT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: warm-up from the zeroed window, threshold and timeout extremes
		for (i = 0; i < DIRECTED_N; i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_regs(directed_rows[i].a, directed_rows[i].b);
			end else begin
				send_sample(directed_rows[i].a[SAMPLE_BITS-1:0], directed_rows[i].pinned,
					directed_rows[i].result);
			end
		end

		// long timeout: get occupied, then run quiet until the block times out
		drain_results();
		write_regs(16'd0, 16'hFFFF);
		send_sample(12'd0, 1'b0, '0);
		send_sample(12'd4095, 1'b0, '0);
		send_sample(12'd2000, 1'b0, '0);
		drain_results();
		write_regs(16'h0FFF, 16'(LONG_TIMEOUT));
		idle_on = 1'b0;
		for (k = 0; k < LONG_QUIET; k++)
			send_sample(SAMPLE_BITS'($urandom), 1'b0, '0);
		idle_on = 1'b1;

		// random phases, each with its own settings; one long hold-off, quiet tail
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results();
			random_settings();
			if (phase == 2)
				hold_request = 1'b1;
			if (phase == RANDOM_PHASES - 1)
				idle_on = 1'b0;
			start = samples_sent;
			while (samples_sent - start < PHASE_ITEMS)
				send_segment();
		end
		drain_results();

		$display("run: %0d sample beats over %0d register settings, %0d occupied / %0d empty",
			samples_sent, settings_used, occ_events, empty_events);
		$display("run: warm-up, threshold and timeout extremes, long quiet run, backpressure");
		if (fail_count == 0) begin
			$display("** presence_detect_moving_average: PASSED **");
		end else begin
			$display("** presence_detect_moving_average: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/pdma_pkg.sv
rtl/core/pdma_sample_if.sv
rtl/core/pdma_result_if.sv
rtl/core/pdma_cfg_regs.sv
rtl/core/pdma_avg.sv
rtl/core/pdma_detect.sv
rtl/core/presence_detect_moving_average.sv
verif/presence_detect_moving_average_tb.sv
